### design/kdlp_pkg.sv
// Package for the key debounce / long-press block: register indexes, channel
// widths and the structs passed between the top level and the core.
// No dependencies.
package kdlp_pkg;

	localparam int unsigned TimeW    = 32;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 2;

	localparam logic [CfgDataW-1:0] DefaultDebounceTime  = 16'd20;
	localparam logic [CfgDataW-1:0] DefaultLongPressTime = 16'd1000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LOW_PRESSED     = 2'd0,
		REG_DEBOUNCE_TIME   = 2'd1,
		REG_LONG_PRESS_TIME = 2'd2
	} kdlp_reg_t;

	typedef struct packed {
		logic                low_pressed;
		logic [CfgDataW-1:0] debounce_time;
		logic [CfgDataW-1:0] long_press_time;
	} kdlp_cfg_t;

	typedef struct packed {
		logic press_event;
		logic release_event;
		logic long_press_event;
		logic is_pressed;
	} kdlp_evt_t;

endpackage

### design/kdlp_key_if.sv
// Input channel of the key debounce block: pin level plus timestamp.
// Depends on kdlp_pkg.
interface kdlp_key_if;
	logic                       valid;
	logic                       ready;
	logic                       pin_level;
	logic [kdlp_pkg::TimeW-1:0] now_time;

	modport source (output valid, pin_level, now_time, input ready);
	modport sink   (input valid, pin_level, now_time, output ready);
endinterface

### design/kdlp_evt_if.sv
// Result channel of the key debounce block: event flags and debounced state.
// No dependencies.
interface kdlp_evt_if;
	logic valid;
	logic ready;
	logic press_event;
	logic release_event;
	logic long_press_event;
	logic is_pressed;

	modport source (output valid, press_event, release_event, long_press_event,
		is_pressed, input ready);
	modport sink   (input valid, press_event, release_event, long_press_event,
		is_pressed, output ready);
endinterface

### design/kdlp_cfg_if.sv
// Register write channel of the key debounce block.
// Depends on kdlp_pkg.
interface kdlp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kdlp_pkg::CfgIdxW-1:0]  index;
	logic [kdlp_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### design/key_debounce_long_press.sv
// Top level of the key debounce / long-press detector: channel registers,
// configuration registers and the core. Depends on kdlp_pkg, the kdlp_*_if
// interfaces and kdlp_core.
//
//   channel  | role   | payload                                            | accepted when
//   ---------+--------+----------------------------------------------------+---------------
//   key_in   | sink   | pin_level, now_time                                | valid & ready
//   evt_out  | source | press_event, release_event, long_press_event,      | valid & ready
//            |        | is_pressed                                         |
//   cfg      | sink   | index (0 polarity, 1 debounce_time,                | valid & ready
//            |        | 2 long_press_time), data                           |
//
// One request per cycle sustained while evt_out is not stalled. A request is
// registered into stage 1, the core computes the result and the next state
// from stage 1, and the result lands in the output register that drives
// evt_out.valid.
// The core state is the only loop; its next state is computed in a single pass.
// Reset clears the core state and loads the register defaults (low level means
// pressed, debounce 20 ms, long press 1000 ms). A stall on evt_out holds
// stage 1 and then key_in.ready; the config port is always ready.
module key_debounce_long_press (
	input  logic   clk,
	input  logic   arst_n,
	kdlp_key_if.sink   key_in,
	kdlp_evt_if.source evt_out,
	kdlp_cfg_if.sink   cfg
);
	import kdlp_pkg::*;

	// Configuration registers.
	kdlp_cfg_t cfg_q;

	// Stage 1: registered request.
	logic             valid_s1;
	logic             pin_level_s1;
	logic [TimeW-1:0] now_time_s1;

	// Output register.
	logic      out_valid_q;
	kdlp_evt_t out_q;

	kdlp_evt_t evt;
	logic      out_free;
	logic      advance;

	assign cfg.ready    = 1'b1;

	// Stage 1 advances whenever the output register is empty or being drained.
	assign out_free     = !out_valid_q || evt_out.ready;
	assign advance      = valid_s1 && out_free;
	assign key_in.ready = !valid_s1 || out_free;

	// Write the addressed register; drop writes to unused indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_pressed     <= 1'b1;
			cfg_q.debounce_time   <= DefaultDebounceTime;
			cfg_q.long_press_time <= DefaultLongPressTime;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOW_PRESSED:     cfg_q.low_pressed     <= cfg.data[0];
				REG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= cfg.data;
				REG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage 1 valid and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_in.ready) begin
				valid_s1 <= key_in.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload: capture the request and the result without reset.
	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			pin_level_s1 <= key_in.pin_level;
			now_time_s1  <= key_in.now_time;
		end
		if (advance) begin
			out_q <= evt;
		end
	end

	kdlp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_level_s1),
		.now_time  (now_time_s1),
		.cfg       (cfg_q),
		.evt       (evt)
	);

	assign evt_out.valid            = out_valid_q;
	assign evt_out.press_event      = out_q.press_event;
	assign evt_out.release_event    = out_q.release_event;
	assign evt_out.long_press_event = out_q.long_press_event;
	assign evt_out.is_pressed       = out_q.is_pressed;

endmodule

### design/kdlp_core.sv
// Debounce and long-press state plus the single-pass next-state logic.
// Depends on kdlp_pkg.
module kdlp_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       pin_level,
	input  logic [kdlp_pkg::TimeW-1:0] now_time,
	input  kdlp_pkg::kdlp_cfg_t        cfg,
	output kdlp_pkg::kdlp_evt_t        evt
);
	import kdlp_pkg::*;

	logic             primed_q;
	logic             prev_raw_q;
	logic             stable_lvl_q;
	logic             pressed_q;
	logic             long_done_q;
	logic [TimeW-1:0] change_stamp_q;
	logic [TimeW-1:0] press_stamp_q;

	logic             means_pressed;
	logic [TimeW-1:0] change_stamp_n;
	logic [TimeW-1:0] press_stamp_n;
	logic [TimeW-1:0] since_change;
	logic [TimeW-1:0] since_press;
	logic             take_level;
	logic             flip;
	logic             pressed_n;
	logic             long_done_mid;
	logic             long_ev;

	assign means_pressed = cfg.low_pressed ? ~pin_level : pin_level;

	always_comb begin
		change_stamp_n = (pin_level != prev_raw_q) ? now_time : change_stamp_q;
		since_change   = now_time - change_stamp_n;
		take_level     = (pin_level != stable_lvl_q) &&
			(since_change >= {{(TimeW-CfgDataW){1'b0}}, cfg.debounce_time});
		flip           = take_level && (means_pressed != pressed_q);
		pressed_n      = flip ? means_pressed : pressed_q;
		long_done_mid  = flip ? 1'b0 : long_done_q;
		press_stamp_n  = (flip && means_pressed) ? now_time : press_stamp_q;
		since_press    = now_time - press_stamp_n;
		long_ev        = pressed_n && !long_done_mid && (cfg.long_press_time != '0) &&
			(since_press >= {{(TimeW-CfgDataW){1'b0}}, cfg.long_press_time});
	end

	always_comb begin
		if (!primed_q) begin
			evt.press_event      = 1'b0;
			evt.release_event    = 1'b0;
			evt.long_press_event = 1'b0;
			evt.is_pressed       = means_pressed;
		end else begin
			evt.press_event      = flip && means_pressed;
			evt.release_event    = flip && !means_pressed;
			evt.long_press_event = long_ev;
			evt.is_pressed       = pressed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			prev_raw_q   <= 1'b0;
			stable_lvl_q <= 1'b0;
			pressed_q    <= 1'b0;
			long_done_q  <= 1'b0;
		end else if (step) begin
			primed_q   <= 1'b1;
			prev_raw_q <= pin_level;
			if (!primed_q) begin
				stable_lvl_q <= pin_level;
				pressed_q    <= means_pressed;
				long_done_q  <= 1'b0;
			end else begin
				if (take_level) begin
					stable_lvl_q <= pin_level;
				end
				pressed_q   <= pressed_n;
				long_done_q <= long_done_mid | long_ev;
			end
		end
	end

	// Stamps are always written by the priming item before first use.
	always_ff @(posedge clk) begin
		if (step) begin
			if (!primed_q) begin
				change_stamp_q <= now_time;
				press_stamp_q  <= now_time;
			end else begin
				change_stamp_q <= change_stamp_n;
				press_stamp_q  <= press_stamp_n;
			end
		end
	end

endmodule
